>>> design/dram_row_buffer_timing_macros.svh
// Assertion macros used by the port-level checker of the row buffer timing block.
`ifndef DRAM_ROW_BUFFER_TIMING_MACROS_SVH
`define DRAM_ROW_BUFFER_TIMING_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DRBT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("row buffer timing check failed");

// Next-cycle implication, disabled during reset.
`define DRBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("row buffer timing check failed");

`endif

>>> design/drbt_pkg.sv
// Package with the types, constants and helpers of the row buffer timing block.
`default_nettype none
package drbt_pkg;

   localparam int ROWS        = 256;
   localparam int COLS        = 256;
   localparam int QUEUE_DEPTH = 16;

   localparam int ROW_W   = $clog2(ROWS);
   localparam int COL_W   = $clog2(COLS);
   localparam int CELL_AW = $clog2(ROWS * COLS);
   localparam int SWEEP_W = COL_W + 1;
   localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int QSUM_W  = QCNT_W + 1;

   localparam int DELAY_W   = 10;
   localparam int ADDR_W    = 16;
   localparam int ROWF_W    = 8;
   localparam int REGF_W    = 5;
   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_DELAY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_DELAY = 1'd1;

   localparam logic [DELAY_W-1:0] ROW_DELAY_RESET = 10'd10;
   localparam logic [DELAY_W-1:0] COL_DELAY_RESET = 10'd2;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_LOAD  = 2'd1,
      OP_STORE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_ACCEPTED = 3'd1,
      EV_REJECTED = 3'd2,
      EV_ACTIVATE = 3'd3,
      EV_WRITEBACK = 3'd4,
      EV_LOAD     = 3'd5,
      EV_STORE    = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      K_ACT = 2'd0,
      K_WB  = 2'd1,
      K_LD  = 2'd2,
      K_ST  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_LOAD = 2'd1,
      S_ACT  = 2'd2,
      S_WB   = 2'd3
   } state_type;

   typedef struct packed {
      kind_type               kind;
      logic [ROW_W-1:0]       row;
      logic [COL_W-1:0]       col;
      logic [REGF_W-1:0]      dst;
      logic [DATA_W-1:0]      value;
      logic [DELAY_W-1:0]     left;
   } activity_type;

   typedef struct packed {
      logic [1:0] push_cnt;
      logic       dec;
      logic       pop;
   } queue_ctl_type;

   typedef struct packed {
      logic                pad;
      logic [DATA_W-1:0]   store_value;
      logic [REGF_W-1:0]   target_register;
      logic [ADDR_W-1:0]   address;
      logic [1:0]          operation;
   } req_type;

   typedef struct packed {
      logic [6:0]          pad;
      logic [DATA_W-1:0]   update_count;
      logic [ROWF_W-1:0]   open_row;
      logic                open_valid;
      logic [REGF_W-1:0]   done_register;
      logic [DATA_W-1:0]   data;
      logic [ADDR_W-1:0]   done_address;
      logic [ROWF_W-1:0]   row;
      logic [2:0]          event_res;
   } rsp_type;

   function automatic logic [QIDX_W-1:0] q_wrap(input logic [QSUM_W-1:0] s);
      logic [QSUM_W-1:0] r;
      r = s;
      if (s >= QSUM_W'(QUEUE_DEPTH)) begin
         r = s - QSUM_W'(QUEUE_DEPTH);
      end
      return r[QIDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> design/drbt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module drbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> design/drbt_queue.sv
// In-order activity queue with a countdown on the head entry.
`default_nettype none
module drbt_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire drbt_pkg::queue_ctl_type   ctl,
   input  wire drbt_pkg::activity_type    push_entries [3],
   output drbt_pkg::activity_type         head,
   output logic [drbt_pkg::QCNT_W-1:0]    count
);

   drbt_pkg::activity_type              entries_ff [drbt_pkg::QUEUE_DEPTH];
   drbt_pkg::activity_type              entries_in [drbt_pkg::QUEUE_DEPTH];
   logic [drbt_pkg::QIDX_W-1:0]         head_ff, head_in;
   logic [drbt_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic [drbt_pkg::QSUM_W-1:0]         tail_sum;
   logic [drbt_pkg::QIDX_W-1:0]         slot;

   always_comb begin
      entries_in = entries_ff;
      head_in    = head_ff;
      count_in   = count_ff + drbt_pkg::QCNT_W'(ctl.push_cnt);
      tail_sum   = drbt_pkg::QSUM_W'(head_ff) + drbt_pkg::QSUM_W'(count_ff);
      slot       = '0;
      for (int j = 0; j < 3; j++) begin
         slot = drbt_pkg::q_wrap(tail_sum + drbt_pkg::QSUM_W'(j));
         if (drbt_pkg::QCNT_W'(j) < drbt_pkg::QCNT_W'(ctl.push_cnt)) begin
            entries_in[slot] = push_entries[j];
         end
      end
      if (ctl.dec) begin
         entries_in[head_ff].left = entries_ff[head_ff].left - 1'b1;
      end
      if (ctl.pop) begin
         head_in  = drbt_pkg::q_wrap(drbt_pkg::QSUM_W'(head_ff) + 1'b1);
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      entries_ff <= entries_in;
   end

   assign head  = entries_ff[head_ff];
   assign count = count_ff;

endmodule
`default_nettype wire

>>> design/dram_row_buffer_timing.sv
// Top level of the DRAM open-row buffer timing block.
// Requests, idle ticks, countdown ticks and store completions give their result in the
// cycle after the transfer; a load completion first reads the row buffer in S_LOAD; an
// activation or an open-row writeback copies one row word per cycle. Throughput: one
// item per cycle while the response is not stalled, outside load completions and row
// moves; the row copy sets the worst case. Reset is synchronous: queue empty, no row
// open, delays 10 and 2; the cell array reads as zero through per-row written flags.
`default_nettype none
module dram_row_buffer_timing (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // operation, address, target_register, store_value, zero pad
   input  wire logic [55:0]   req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // event_res, row, done_address, data, done_register, open_valid, open_row,
   // update_count, zero pad
   output logic [111:0]       rsp_tdata,
   input  wire logic          csr_we,
   input  wire logic [drbt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [drbt_pkg::DELAY_W-1:0]   csr_wdata
);

   drbt_pkg::state_type                 state_ff, state_in;
   logic [drbt_pkg::SWEEP_W-1:0]        cnt_ff, cnt_in, cnt_m1;
   logic [drbt_pkg::ROW_W-1:0]          act_row_ff, act_row_in;
   logic                                act_fill_ff, act_fill_in;
   logic [drbt_pkg::REGF_W-1:0]         ld_reg_ff, ld_reg_in;
   logic                                row_open_ff, row_open_in;
   logic [drbt_pkg::ROW_W-1:0]          open_index_ff, open_index_in;
   logic [drbt_pkg::DATA_W-1:0]         updates_ff, updates_in;
   logic                                row_written_ff [drbt_pkg::ROWS];
   logic                                row_written_in [drbt_pkg::ROWS];
   logic [drbt_pkg::DELAY_W-1:0]        row_delay_ff, col_delay_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   drbt_pkg::rsp_type                   rsp_data_ff, rsp_data_in, rsp_next;

   drbt_pkg::req_type                   req;
   drbt_pkg::queue_ctl_type             q_ctl;
   drbt_pkg::activity_type              push_entries [3];
   drbt_pkg::activity_type              q_head;
   logic [drbt_pkg::QCNT_W-1:0]         q_count;
   drbt_pkg::activity_type              act_ent, wb_ent, col_ent;

   logic                                accept, send;
   logic [drbt_pkg::ROW_W-1:0]          trow;
   logic [drbt_pkg::COL_W-1:0]          tcol;
   logic [drbt_pkg::DELAY_W-1:0]        row_left, col_left;

   logic                                cell_we;
   logic [drbt_pkg::CELL_AW-1:0]        cell_waddr, cell_raddr;
   logic [drbt_pkg::DATA_W-1:0]         cell_rdata;
   logic                                rs_we;
   logic [drbt_pkg::COL_W-1:0]          rs_waddr, rs_raddr;
   logic [drbt_pkg::DATA_W-1:0]         rs_wdata, rs_rdata;

   assign req        = drbt_pkg::req_type'(req_tdata);
   assign req_tready = (state_ff == drbt_pkg::S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign trow       = drbt_pkg::ROW_W'((req.address / drbt_pkg::COLS) % drbt_pkg::ROWS);
   assign tcol       = drbt_pkg::COL_W'(req.address % drbt_pkg::COLS);
   assign row_left   = (row_delay_ff == '0) ? drbt_pkg::DELAY_W'(1) : row_delay_ff;
   assign col_left   = (col_delay_ff == '0) ? drbt_pkg::DELAY_W'(1) : col_delay_ff;
   assign cnt_m1     = cnt_ff - 1'b1;

   always_comb begin
      act_ent       = '0;
      act_ent.kind  = drbt_pkg::K_ACT;
      act_ent.row   = trow;
      act_ent.left  = row_left;
      wb_ent        = '0;
      wb_ent.kind   = drbt_pkg::K_WB;
      wb_ent.left   = row_left;
      col_ent       = '0;
      col_ent.col   = tcol;
      col_ent.left  = col_left;
      if (req.operation == drbt_pkg::OP_LOAD) begin
         col_ent.kind = drbt_pkg::K_LD;
         col_ent.dst  = req.target_register;
      end else begin
         col_ent.kind  = drbt_pkg::K_ST;
         col_ent.value = req.store_value;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      act_row_in     = act_row_ff;
      act_fill_in    = act_fill_ff;
      ld_reg_in      = ld_reg_ff;
      row_open_in    = row_open_ff;
      open_index_in  = open_index_ff;
      updates_in     = updates_ff;
      row_written_in = row_written_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_next       = '0;
      send           = 1'b0;
      q_ctl          = '0;
      push_entries[0] = '0;
      push_entries[1] = '0;
      push_entries[2] = '0;
      cell_we        = 1'b0;
      cell_waddr     = drbt_pkg::CELL_AW'(open_index_ff) * drbt_pkg::CELL_AW'(drbt_pkg::COLS)
                       + drbt_pkg::CELL_AW'(cnt_m1[drbt_pkg::COL_W-1:0]);
      cell_raddr     = drbt_pkg::CELL_AW'(act_row_ff) * drbt_pkg::CELL_AW'(drbt_pkg::COLS)
                       + drbt_pkg::CELL_AW'(cnt_ff[drbt_pkg::COL_W-1:0]);
      rs_we          = 1'b0;
      rs_waddr       = cnt_m1[drbt_pkg::COL_W-1:0];
      rs_wdata       = act_fill_ff ? cell_rdata : '0;
      rs_raddr       = cnt_ff[drbt_pkg::COL_W-1:0];

      case (state_ff)
         drbt_pkg::S_IDLE: begin
            if (accept) begin
               send = 1'b1;
               case (req.operation)
                  drbt_pkg::OP_LOAD, drbt_pkg::OP_STORE: begin
                     if (q_count > drbt_pkg::QCNT_W'(drbt_pkg::QUEUE_DEPTH - 3)) begin
                        rsp_next.event_res = drbt_pkg::EV_REJECTED;
                     end else begin
                        rsp_next.event_res = drbt_pkg::EV_ACCEPTED;
                        if (row_open_ff && open_index_ff == trow) begin
                           push_entries[0] = col_ent;
                           q_ctl.push_cnt  = 2'd1;
                        end else if (row_open_ff) begin
                           push_entries[0] = wb_ent;
                           push_entries[1] = act_ent;
                           push_entries[2] = col_ent;
                           q_ctl.push_cnt  = 2'd3;
                        end else begin
                           push_entries[0] = act_ent;
                           push_entries[1] = col_ent;
                           q_ctl.push_cnt  = 2'd2;
                        end
                     end
                  end
                  drbt_pkg::OP_TICK: begin
                     if (q_count != '0) begin
                        if (q_head.left != drbt_pkg::DELAY_W'(1)) begin
                           q_ctl.dec = 1'b1;
                        end else begin
                           q_ctl.pop = 1'b1;
                           case (q_head.kind)
                              drbt_pkg::K_ACT: begin
                                 send        = 1'b0;
                                 act_row_in  = q_head.row;
                                 act_fill_in = row_written_ff[q_head.row];
                                 cnt_in      = '0;
                                 state_in    = drbt_pkg::S_ACT;
                              end
                              drbt_pkg::K_WB: begin
                                 if (row_open_ff) begin
                                    send     = 1'b0;
                                    cnt_in   = '0;
                                    state_in = drbt_pkg::S_WB;
                                 end else begin
                                    rsp_next.event_res = drbt_pkg::EV_WRITEBACK;
                                 end
                              end
                              drbt_pkg::K_LD: begin
                                 send      = 1'b0;
                                 rs_raddr  = q_head.col;
                                 ld_reg_in = q_head.dst;
                                 state_in  = drbt_pkg::S_LOAD;
                              end
                              default: begin
                                 rs_we    = 1'b1;
                                 rs_waddr = q_head.col;
                                 rs_wdata = q_head.value;
                                 updates_in = updates_ff + 1'b1;
                                 rsp_next.event_res = drbt_pkg::EV_STORE;
                                 rsp_next.data      = q_head.value;
                                 rsp_next.done_address = drbt_pkg::ADDR_W'(
                                    drbt_pkg::CELL_AW'(open_index_ff)
                                    * drbt_pkg::CELL_AW'(drbt_pkg::COLS)
                                    + drbt_pkg::CELL_AW'(q_head.col));
                              end
                           endcase
                        end
                     end
                  end
                  default: begin
                     rsp_next.event_res = drbt_pkg::EV_NONE;
                  end
               endcase
            end
         end
         drbt_pkg::S_LOAD: begin
            send                   = 1'b1;
            rsp_next.event_res     = drbt_pkg::EV_LOAD;
            rsp_next.data          = rs_rdata;
            rsp_next.done_register = ld_reg_ff;
            state_in               = drbt_pkg::S_IDLE;
         end
         drbt_pkg::S_ACT: begin
            cnt_in = cnt_ff + 1'b1;
            rs_we  = (cnt_ff != '0);
            if (cnt_ff == drbt_pkg::SWEEP_W'(drbt_pkg::COLS)) begin
               send               = 1'b1;
               row_open_in        = 1'b1;
               open_index_in      = act_row_ff;
               updates_in         = updates_ff + 1'b1;
               rsp_next.event_res = drbt_pkg::EV_ACTIVATE;
               rsp_next.row       = drbt_pkg::ROWF_W'(act_row_ff);
               state_in           = drbt_pkg::S_IDLE;
            end
         end
         drbt_pkg::S_WB: begin
            cnt_in  = cnt_ff + 1'b1;
            cell_we = (cnt_ff != '0);
            if (cnt_ff == drbt_pkg::SWEEP_W'(drbt_pkg::COLS)) begin
               send                          = 1'b1;
               row_open_in                   = 1'b0;
               row_written_in[open_index_ff] = 1'b1;
               rsp_next.event_res            = drbt_pkg::EV_WRITEBACK;
               rsp_next.row                  = drbt_pkg::ROWF_W'(open_index_ff);
               state_in                      = drbt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = drbt_pkg::S_IDLE;
         end
      endcase

      rsp_next.open_valid   = row_open_in;
      rsp_next.open_row     = row_open_in ? drbt_pkg::ROWF_W'(open_index_in) : '0;
      rsp_next.update_count = updates_in;
      if (send) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= drbt_pkg::S_IDLE;
         cnt_ff        <= '0;
         row_open_ff   <= 1'b0;
         open_index_ff <= '0;
         updates_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         row_delay_ff  <= drbt_pkg::ROW_DELAY_RESET;
         col_delay_ff  <= drbt_pkg::COL_DELAY_RESET;
         for (int r = 0; r < drbt_pkg::ROWS; r++) begin
            row_written_ff[r] <= 1'b0;
         end
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         row_open_ff    <= row_open_in;
         open_index_ff  <= open_index_in;
         updates_ff     <= updates_in;
         rsp_valid_ff   <= rsp_valid_in;
         row_written_ff <= row_written_in;
         if (csr_we && csr_index == drbt_pkg::CSR_ROW_DELAY) begin
            row_delay_ff <= csr_wdata;
         end
         if (csr_we && csr_index == drbt_pkg::CSR_COL_DELAY) begin
            col_delay_ff <= csr_wdata;
         end
      end
      act_row_ff  <= act_row_in;
      act_fill_ff <= act_fill_in;
      ld_reg_ff   <= ld_reg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   drbt_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .ctl          (q_ctl),
      .push_entries (push_entries),
      .head         (q_head),
      .count        (q_count)
   );

   drbt_ram #(
      .WIDTH (drbt_pkg::DATA_W),
      .DEPTH (drbt_pkg::ROWS * drbt_pkg::COLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (rs_rdata),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   drbt_ram #(
      .WIDTH (drbt_pkg::DATA_W),
      .DEPTH (drbt_pkg::COLS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (rs_we),
      .wr_addr (rs_waddr),
      .wr_data (rs_wdata),
      .rd_addr (rs_raddr),
      .rd_data (rs_rdata)
   );

endmodule
`default_nettype wire

>>> design/drbt_checker.sv
// Port-level checker for the row buffer timing block, bound to the top level.
`default_nettype none
`include "dram_row_buffer_timing_macros.svh"
module drbt_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          req_tvalid,
   input wire logic          req_tready,
   input wire logic [55:0]   req_tdata,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [111:0]  rsp_tdata,
   input wire logic          csr_we,
   input wire logic [drbt_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [drbt_pkg::DELAY_W-1:0]   csr_wdata
);

   `DRBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `DRBT_ASSERT_NOW(a_no_accept_on_stall, clock, reset, rsp_tvalid && !rsp_tready,
      !req_tready)
   `DRBT_ASSERT_NEXT(a_result_or_busy, clock, reset, req_tvalid && req_tready,
      rsp_tvalid || !req_tready)
   `DRBT_ASSERT_NOW(a_closed_row_zero, clock, reset, rsp_tvalid && !rsp_tdata[64],
      rsp_tdata[72:65] == 8'd0)

endmodule

bind dram_row_buffer_timing drbt_checker u_drbt_checker (.*);
`default_nettype wire
